### hw/rtl/bounded_deque_with_value_count_core_assert.svh
// Assertion macros used by the deque core top level.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef BOUNDED_DEQUE_WITH_VALUE_COUNT_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_VALUE_COUNT_CORE_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define BDQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque core.
// No dependencies; imported by bdq_cell and the top level.
package bdq_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_COUNT      = 3'd4,
    KIND_SIZE       = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every storage cell.
  typedef struct packed {
    logic shr;   // take the left neighbor's word (push at the front)
    logic shl;   // take the right neighbor's word (pop front or rotate)
    logic ld;    // the cell at the back slot takes the pushed word
  } cell_op_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FIELD_W = 7;

endpackage

### hw/rtl/bdq_cell.sv
// One storage cell of the deque chain: holds a single entry.
// Depends on bdq_pkg for the command struct.
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX   = 0
) (
  input  logic                         clk,
  input  cell_op_t                     op,
  input  logic [$clog2(DEPTH+1)-1:0]   fill,
  input  logic [DATA_W-1:0]            push_val,
  input  logic [DATA_W-1:0]            left_d,
  input  logic [DATA_W-1:0]            right_d,
  output logic [DATA_W-1:0]            q
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_back;

  // This cell is the first free slot behind the back entry.
  assign at_back = (fill == CW'(IDX));

  always_comb begin
    data_nxt = data_r;
    priority if (op.shr) begin
      data_nxt = left_d;
    end else if (op.shl) begin
      data_nxt = right_d;
    end else if (op.ld && at_back) begin
      data_nxt = push_val;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

### hw/rtl/bounded_deque_with_value_count_core.sv
// Bounded deque of signed 32-bit values held in a chain of DEPTH cells, front in cell 0.
// Pushes, pop front, size, the unused kinds and a pop on an empty queue load the result
// register on the input transfer, one item per cycle while the result is taken.
// Pop back and count matches rotate the chain once through cell 0 before the result is
// registered, and no new transfer is accepted until the rotation has finished.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
`include "bounded_deque_with_value_count_core_assert.svh"

module bounded_deque_with_value_count_core
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] popped_value, [38:32] match_count,
                                  // [45:39] occupancy, [47:46] status
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Widen or trim a count to the 7-bit result fields.
  function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
    logic [CW+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, v};
    return w[FIELD_W-1:0];
  endfunction

  state_t               state_r;
  logic [CW-1:0]        fill_r;
  logic [IW-1:0]        step_r;
  logic [DATA_W-1:0]    val_r;
  logic                 scan_pop_r;   // the running scan serves a pop at the back
  logic [CW-1:0]        match_r;
  logic [DATA_W-1:0]    pop_r;

  logic                 out_tvalid_r;
  logic [DATA_W-1:0]    out_pop_r;
  logic [FIELD_W-1:0]   out_match_r;
  logic [FIELD_W-1:0]   out_occ_r;
  status_t              out_st_r;

  logic [DATA_W-1:0]    cell_q [DEPTH];
  cell_op_t             cell_op;

  kind_t                in_kind;
  logic [DATA_W-1:0]    in_value;
  logic                 in_fire;
  logic                 out_free;
  logic                 full;
  logic                 empty;
  logic                 scan_adv;
  logic                 scan_done;
  logic [CW-1:0]        step_ext;
  logic                 in_span;
  logic                 hit;
  logic [CW-1:0]        match_nxt;
  logic [DATA_W-1:0]    pop_nxt;

  assign in_kind  = kind_t'(in_tuser);
  assign in_value = in_tdata;

  // The output register frees up when it is empty or its transfer completes this cycle.
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign full  = (fill_r == CW'(DEPTH));
  assign empty = (fill_r == '0);

  // A scan rotates the chain one place per cycle; the final rotation waits until the
  // result can be written, so the chain always comes back to its original alignment.
  assign scan_done = (state_r == S_SCAN) && (step_r == LAST_STEP) && out_free;
  assign scan_adv  = (state_r == S_SCAN) && ((step_r != LAST_STEP) || out_free);

  // After step_r rotations, cell 0 holds the entry at offset step_r from the front.
  assign step_ext  = CW'(step_r);
  assign in_span   = (step_ext < fill_r);
  assign hit       = in_span && (cell_q[0] == val_r);
  assign match_nxt = match_r + CW'(hit);
  assign pop_nxt   = (in_span && (step_ext == fill_r - CW'(1))) ? cell_q[0] : pop_r;

  // Commands to the chain.
  always_comb begin
    cell_op = '0;
    if (in_fire) begin
      unique case (in_kind)
        KIND_PUSH_FRONT: cell_op.shr = !full;
        KIND_PUSH_BACK:  cell_op.ld  = !full;
        KIND_POP_FRONT:  cell_op.shl = !empty;
        default:         cell_op     = '0;
      endcase
    end else if (scan_adv) begin
      cell_op.shl = 1'b1;
    end
  end

  // Chain of cells. Each cell takes its left neighbor on a front push and its right
  // neighbor on a front pop or a rotation; the last cell wraps round to cell 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % DEPTH;
    logic [DATA_W-1:0] left_d;

    if (g == 0) begin : g_head
      assign left_d = in_value;
    end else begin : g_body
      assign left_d = cell_q[g-1];
    end

    bdq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .fill     (fill_r),
      .push_val (in_value),
      .left_d   (left_d),
      .right_d  (cell_q[NXT]),
      .q        (cell_q[g])
    );
  end

  // Control state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      step_r       <= '0;
      scan_pop_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            out_pop_r   <= '0;
            out_match_r <= '0;
            out_occ_r   <= to_field(fill_r);
            out_st_r    <= ST_OK;
            val_r       <= in_value;
            match_r     <= '0;
            pop_r       <= '0;
            step_r      <= '0;
            unique case (in_kind)
              KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                out_tvalid_r <= 1'b1;
                if (full) begin
                  out_st_r <= ST_FULL;
                end else begin
                  fill_r    <= fill_r + CW'(1);
                  out_occ_r <= to_field(fill_r + CW'(1));
                end
              end
              KIND_POP_FRONT: begin
                out_tvalid_r <= 1'b1;
                if (empty) begin
                  out_st_r <= ST_EMPTY;
                end else begin
                  fill_r    <= fill_r - CW'(1);
                  out_occ_r <= to_field(fill_r - CW'(1));
                  out_pop_r <= cell_q[0];
                end
              end
              KIND_POP_BACK: begin
                if (empty) begin
                  out_tvalid_r <= 1'b1;
                  out_st_r     <= ST_EMPTY;
                end else begin
                  scan_pop_r <= 1'b1;
                  state_r    <= S_SCAN;
                end
              end
              KIND_COUNT: begin
                scan_pop_r <= 1'b0;
                state_r    <= S_SCAN;
              end
              default: begin
                // Size, and the unused kinds, only report the occupancy.
                out_tvalid_r <= 1'b1;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_adv) begin
            step_r  <= step_r + IW'(1);
            match_r <= match_nxt;
            pop_r   <= pop_nxt;
          end
          if (scan_done) begin
            state_r      <= S_IDLE;
            step_r       <= '0;
            out_tvalid_r <= 1'b1;
            out_st_r     <= ST_OK;
            if (scan_pop_r) begin
              out_pop_r   <= pop_nxt;
              out_match_r <= '0;
              out_occ_r   <= to_field(fill_r - CW'(1));
              fill_r      <= fill_r - CW'(1);
            end else begin
              out_pop_r   <= '0;
              out_match_r <= to_field(match_nxt);
              out_occ_r   <= to_field(fill_r);
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_st_r, out_occ_r, out_match_r, out_pop_r};

  // The queue never holds more than DEPTH entries.
  `BDQ_ASSERT_ALWAYS(a_fill_bound, fill_r <= CW'(DEPTH), "fill count above DEPTH")

  // The fill count moves by at most one entry per cycle.
  `BDQ_ASSERT_ALWAYS(a_fill_step,
    (fill_r == $past(fill_r)) || (fill_r == $past(fill_r) + CW'(1)) ||
    (fill_r + CW'(1) == $past(fill_r)), "fill count jumped")

  // Operations that need no rotation leave a result in the next cycle.
  `BDQ_ASSERT_NEXT(a_fast_result,
    in_fire && (in_kind != KIND_COUNT) && !((in_kind == KIND_POP_BACK) && !empty),
    out_tvalid_r && (state_r == S_IDLE), "single-cycle operation gave no result")

endmodule
